### rtl/hds_pkg.sv
// Shared constants and types for the heat diffusion stencil step block.
`timescale 1ns / 1ps
`default_nettype none

package hds_pkg;

  // Field widths
  localparam int VAL_W      = 16;
  localparam int COLS_CFG_W = 8;
  localparam int ROWS_W     = 12;
  localparam int ALPHA_W    = 15;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA          = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_VALUE = 2'd3;

  // Register reset values
  localparam logic [COLS_CFG_W-1:0] GRID_COLS_RST      = 8'd100;
  localparam logic [ROWS_W-1:0]     GRID_ROWS_RST      = 12'd100;
  localparam logic [ALPHA_W-1:0]    ALPHA_RST          = 15'd6554;
  localparam logic [VAL_W-1:0]      BOUNDARY_VALUE_RST = 16'd6400;

  // Default line buffer depth
  localparam int MAX_COLS_DEF = 128;

  // Five-point neighborhood of one cell
  typedef struct packed {
    logic [VAL_W-1:0] mid;
    logic [VAL_W-1:0] up;
    logic [VAL_W-1:0] down;
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] right;
  } hds_nbr_t;

  // Per-item control flags carried in the input stage
  typedef struct packed {
    logic emit;      // item produces a result
    logic last;      // result is the final cell of the frame
    logic up_bv;     // upper neighbor lies outside the grid
    logic left_bv;   // left neighbor lies outside the grid
    logic right_bv;  // right neighbor lies outside the grid
  } hds_flags_t;

endpackage

`default_nettype wire

### rtl/hds_if.sv
// Valid/ready stream interfaces for the input and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface hds_in_if import hds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] cell_value;
  logic             is_flush;

  modport source (output valid, output cell_value, output is_flush, input ready);
  modport sink   (input valid, input cell_value, input is_flush, output ready);
endinterface

interface hds_out_if import hds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] new_value;
  logic             last_of_frame;

  modport source (output valid, output new_value, output last_of_frame, input ready);
  modport sink   (input valid, input new_value, input last_of_frame, output ready);
endinterface

`default_nettype wire

### rtl/hds_linebuf.sv
// Line buffer memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module hds_linebuf #(
  parameter int DEPTH = 128,
  parameter int W     = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr0_i,
  input  logic [AW-1:0] raddr1_i,
  output logic [W-1:0]  rdata0_o,
  output logic [W-1:0]  rdata1_o
);

  logic [W-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read two entries; a same-edge write is seen on the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem[raddr0_i];
      rdata1_o <= mem[raddr1_i];
    end
  end

endmodule

`default_nettype wire

### rtl/hds_alu.sv
// Five-point FTCS update with floor shift and saturation.
`timescale 1ns / 1ps
`default_nettype none

module hds_alu import hds_pkg::*; (
  input  hds_nbr_t           nbr_i,
  input  logic [ALPHA_W-1:0] alpha_i,
  output logic [VAL_W-1:0]   value_o
);

  logic        [17:0] sum4;
  logic signed [18:0] lap;
  logic signed [34:0] prod;
  logic signed [18:0] delta;
  logic signed [18:0] total;

  // Sum neighbors and subtract four times the center
  assign sum4 = 18'(nbr_i.up) + 18'(nbr_i.down) + 18'(nbr_i.left) + 18'(nbr_i.right);
  assign lap  = $signed({1'b0, sum4}) - $signed({1'b0, nbr_i.mid, 2'b00});

  // Scale by alpha; keep the upper bits for a floor shift by 16
  assign prod  = 35'($signed({1'b0, alpha_i})) * 35'(lap);
  assign delta = prod[34:16];
  assign total = $signed({3'b000, nbr_i.mid}) + delta;

  // Clamp to the unsigned value range
  always_comb begin
    if (total[18]) begin
      value_o = '0;
    end else if (total[17:16] != 2'b00) begin
      value_o = '1;
    end else begin
      value_o = total[15:0];
    end
  end

endmodule

`default_nettype wire

### rtl/heat_diffusion_stencil_step_core.sv
// A result is registered when the item one row below its cell leaves the input stage.
// One item per cycle unless output stalls, set by the input stage, line buffer reads and ALU.
// Each line buffer takes one write and two reads per cycle; a one-entry bypass covers the
// write that lands on the same edge as a read.
// Reset clears the row and column counters and both pipeline stages and loads the register
// defaults; the line buffers are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module heat_diffusion_stencil_step_core import hds_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  hds_in_if.sink                in_if,
  hds_out_if.source             out_if
);

  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W = ($clog2(MAX_COLS + 1) > COLS_CFG_W) ? $clog2(MAX_COLS + 1)
                                                             : COLS_CFG_W;

  // Configuration registers
  logic [COLS_CFG_W-1:0] grid_cols_q;
  logic [ROWS_W-1:0]     grid_rows_q;
  logic [ALPHA_W-1:0]    alpha_q;
  logic [VAL_W-1:0]      bound_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= GRID_COLS_RST;
      grid_rows_q <= GRID_ROWS_RST;
      alpha_q     <= ALPHA_RST;
      bound_q     <= BOUNDARY_VALUE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_COLS:      grid_cols_q <= cfg_wdata_i[COLS_CFG_W-1:0];
        REG_GRID_ROWS:      grid_rows_q <= cfg_wdata_i[ROWS_W-1:0];
        REG_ALPHA:          alpha_q     <= cfg_wdata_i[ALPHA_W-1:0];
        REG_BOUNDARY_VALUE: bound_q     <= cfg_wdata_i[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid size
  logic [CNT_W-1:0]  cols_eff;
  logic [CW-1:0]     last_c;
  logic [ROWS_W-1:0] rows_eff;

  always_comb begin
    cols_eff = CNT_W'(grid_cols_q);
    if (cols_eff == '0) begin
      cols_eff = CNT_W'(1);
    end else if (cols_eff > CNT_W'(MAX_COLS)) begin
      cols_eff = CNT_W'(MAX_COLS);
    end
    last_c   = CW'(cols_eff - CNT_W'(1));
    rows_eff = (grid_rows_q == '0) ? ROWS_W'(1) : grid_rows_q;
  end

  // Raster position
  logic [CW-1:0]     col_q, col_d;
  logic [ROWS_W-1:0] row_q, row_d;

  // Input stage
  logic             s1_valid_q, s1_valid_d;
  hds_flags_t       s1_flags_q;
  logic [CW-1:0]    s1_c_q, s1_cp1_q, s1_cm1_q;
  logic [VAL_W-1:0] s1_down_q;

  // Bypass of the write that shares an edge with the stage's reads
  logic             fwd_valid_q;
  logic [CW-1:0]    fwd_c_q;
  logic [VAL_W-1:0] fwd_above_q, fwd_center_q;

  // Result register
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] new_value_q;
  logic             last_q;

  logic             in_acc, flushing, item_use, at_last, s1_adv, s1_load, out_load;
  logic [CW-1:0]    c_cur, c_p1, c_m1;
  logic [VAL_W-1:0] down_in;
  hds_flags_t       flags_in;
  hds_nbr_t         nbr;

  // Classify the incoming item
  always_comb begin
    in_acc   = in_if.valid && in_if.ready;
    flushing = row_q >= rows_eff;
    item_use = in_acc && (in_if.is_flush == flushing);
    c_cur    = (col_q > last_c) ? last_c : col_q;
    c_p1     = c_cur + CW'(1);
    c_m1     = c_cur - CW'(1);
    at_last  = c_cur == last_c;
    down_in  = flushing ? bound_q : in_if.cell_value;

    flags_in.emit     = row_q != '0;
    flags_in.last     = flushing && at_last;
    flags_in.up_bv    = row_q == ROWS_W'(1);
    flags_in.left_bv  = c_cur == '0;
    flags_in.right_bv = at_last;
  end

  // Advance the stage when its result has a place to go
  assign s1_adv      = s1_valid_q && (!s1_flags_q.emit || !out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || s1_adv;
  assign s1_load     = item_use;
  assign out_load    = s1_adv && s1_flags_q.emit;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Step the raster counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (item_use) begin
      if (at_last) begin
        col_d = '0;
        row_d = flushing ? '0 : row_q + ROWS_W'(1);
      end else begin
        col_d = c_p1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_load) begin
        fwd_valid_q <= s1_adv;
      end
    end
  end

  // Capture the item and the write leaving on the same edge
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_flags_q   <= flags_in;
      s1_c_q       <= c_cur;
      s1_cp1_q     <= c_p1;
      s1_cm1_q     <= c_m1;
      s1_down_q    <= down_in;
      fwd_c_q      <= s1_c_q;
      fwd_above_q  <= nbr.mid;
      fwd_center_q <= s1_down_q;
    end
  end

  // Line buffers
  logic [VAL_W-1:0] abv_rd0, abv_rd1, ctr_rd0, ctr_rd1;

  hds_linebuf #(.DEPTH(MAX_COLS), .W(VAL_W)) u_above (
    .clk_i    (clk_i),
    .we_i     (s1_adv),
    .waddr_i  (s1_c_q),
    .wdata_i  (nbr.mid),
    .re_i     (s1_load),
    .raddr0_i (c_cur),
    .raddr1_i (c_m1),
    .rdata0_o (abv_rd0),
    .rdata1_o (abv_rd1)
  );

  hds_linebuf #(.DEPTH(MAX_COLS), .W(VAL_W)) u_center (
    .clk_i    (clk_i),
    .we_i     (s1_adv),
    .waddr_i  (s1_c_q),
    .wdata_i  (s1_down_q),
    .re_i     (s1_load),
    .raddr0_i (c_cur),
    .raddr1_i (c_p1),
    .rdata0_o (ctr_rd0),
    .rdata1_o (ctr_rd1)
  );

  // Assemble the neighborhood, bypassing the last write and applying the boundary
  always_comb begin
    nbr.mid   = (fwd_valid_q && fwd_c_q == s1_c_q)   ? fwd_center_q : ctr_rd0;
    nbr.right = (fwd_valid_q && fwd_c_q == s1_cp1_q) ? fwd_center_q : ctr_rd1;
    nbr.up    = (fwd_valid_q && fwd_c_q == s1_c_q)   ? fwd_above_q  : abv_rd0;
    nbr.left  = (fwd_valid_q && fwd_c_q == s1_cm1_q) ? fwd_above_q  : abv_rd1;
    nbr.down  = s1_down_q;
    if (s1_flags_q.up_bv) begin
      nbr.up = bound_q;
    end
    if (s1_flags_q.left_bv) begin
      nbr.left = bound_q;
    end
    if (s1_flags_q.right_bv) begin
      nbr.right = bound_q;
    end
  end

  logic [VAL_W-1:0] alu_value;

  hds_alu u_alu (
    .nbr_i   (nbr),
    .alpha_i (alpha_q),
    .value_o (alu_value)
  );

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      new_value_q <= alu_value;
      last_q      <= s1_flags_q.last;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.new_value     = new_value_q;
  assign out_if.last_of_frame = last_q;

  // A new result comes only from a stage item that emits
  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_flags_q.emit))
    else $error("result appeared without an emitting stage item");

  // A blocked stage takes no new item
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_flags_q.emit && out_valid_q && !out_if.ready) |-> !in_if.ready)
    else $error("input accepted while stage is blocked");

  // The final flush cell restarts the frame
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_use && flags_in.last) |=> (row_q == '0 && col_q == '0))
    else $error("frame did not restart after last cell");

  // The bypass records whether a write shared the load edge
  a_bypass_tracks_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_load |=> (fwd_valid_q == $past(s1_adv)))
    else $error("bypass flag out of step with line buffer write");

endmodule

`default_nettype wire

### tb/sv/heat_diffusion_stencil_step_core_tb.sv
// Testbench for the heat diffusion stencil step core: raster frames checked against a cell predictor.
`timescale 1ns / 1ps

module heat_diffusion_stencil_step_core_tb;
  import hds_pkg::*;

  localparam int MAX_COLS = MAX_COLS_DEF;

  typedef struct packed {
    logic [VAL_W-1:0] new_value;
    logic             last_of_frame;
  } cell_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  hds_in_if  in_if ();
  hds_out_if out_if ();

  heat_diffusion_stencil_step_core #(
    .MAX_COLS (MAX_COLS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  // Predictor state: register copies, line buffers and raster position
  logic [COLS_CFG_W-1:0] cfg_cols;
  logic [ROWS_W-1:0]     cfg_rows;
  logic [ALPHA_W-1:0]    cfg_alpha;
  logic [VAL_W-1:0]      cfg_boundary;
  logic [VAL_W-1:0]      line_above [MAX_COLS];
  logic [VAL_W-1:0]      line_center [MAX_COLS];
  logic [ROWS_W-1:0]     rows_seen;
  int unsigned           col_idx;

  cell_result_t pending_cells [$];
  int unsigned  mismatches;
  int unsigned  fed_cells;
  int unsigned  sink_hold;
  bit           steady;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned active_cols();
    int unsigned n;
    n = 32'(cfg_cols);
    if (n == 0) n = 1;
    if (n > MAX_COLS) n = MAX_COLS;
    return n;
  endfunction

  function automatic int unsigned active_rows();
    return (cfg_rows == 0) ? 1 : 32'(cfg_rows);
  endfunction

  // One FTCS update: floor shift of alpha times the Laplacian, then clamp to 16 bits
  function automatic logic [VAL_W-1:0] ftcs_update(input logic [VAL_W-1:0] mid_v, up_v, down_v,
                                                   left_v, right_v);
    longint m;
    longint lap;
    longint gain;
    longint sum;
    m = 64'(mid_v);
    lap = 64'(up_v) + 64'(down_v) + 64'(left_v) + 64'(right_v);
    lap = lap - 4 * m;
    gain = 64'(cfg_alpha);
    sum = m + ((gain * lap) >>> 16);
    if (sum < 0) sum = 0;
    if (sum > 65535) sum = 65535;
    return sum[VAL_W-1:0];
  endfunction

  // Advance the raster position by one item; queue its cell if it emits one.
  // Return 0 when the item is of the wrong phase and gets dropped.
  function automatic bit advance_grid(input logic [VAL_W-1:0] cell_v, input logic flush);
    int unsigned      cols;
    int unsigned      c;
    logic             flushing;
    logic [VAL_W-1:0] bv;
    logic [VAL_W-1:0] down_v;
    logic [VAL_W-1:0] up_v;
    logic [VAL_W-1:0] left_v;
    logic [VAL_W-1:0] right_v;
    cell_result_t     res;
    cols = active_cols();
    flushing = 32'(rows_seen) >= active_rows();
    if (flush != flushing) return 1'b0;
    c = (col_idx >= cols) ? cols - 1 : col_idx;
    bv = cfg_boundary;
    down_v = flushing ? bv : cell_v;
    if (rows_seen != 0) begin
      up_v = (rows_seen == 1) ? bv : line_above[c];
      left_v = (c == 0) ? bv : line_above[c - 1];
      right_v = (c + 1 >= cols) ? bv : line_center[c + 1];
      res.new_value = ftcs_update(line_center[c], up_v, down_v, left_v, right_v);
      res.last_of_frame = flushing && (c == cols - 1);
      pending_cells.push_back(res);
    end
    line_above[c] = line_center[c];
    line_center[c] = down_v;
    if (c == cols - 1) begin
      col_idx = 0;
      rows_seen = flushing ? '0 : rows_seen + 1'b1;
    end else begin
      col_idx = c + 1;
    end
    return 1'b1;
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_cell(input logic [VAL_W-1:0] got_value, input logic got_last);
    cell_result_t want;
    if (pending_cells.size() == 0) begin
      report_mismatch($sformatf("unexpected item new_value=%0d last_of_frame=%0b",
                                got_value, got_last));
      return;
    end
    want = pending_cells.pop_front();
    if (got_value !== want.new_value)
      report_mismatch($sformatf("new_value expected %0d, got %0d", want.new_value, got_value));
    if (got_last !== want.last_of_frame)
      report_mismatch($sformatf("last_of_frame expected %0b, got %0b",
                                want.last_of_frame, got_last));
  endfunction

  // Result side: check each accepted item, then stall for a random number of cycles
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      check_cell(out_if.new_value, out_if.last_of_frame);
      sink_hold = steady ? 0 : $urandom_range(0, 8);
      if (sink_hold != 0) out_if.ready <= 1'b0;
    end else if (!out_if.ready) begin
      if (sink_hold > 1) sink_hold--;
      else out_if.ready <= 1'b1;
    end
  end

  // Mostly random temperatures, with the extremes and values near the boundary mixed in
  function automatic logic [VAL_W-1:0] pick_temp();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return cfg_boundary + VAL_W'($urandom_range(0, 63)) - VAL_W'(32);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Send one item after a random gap; hold valid high when no gap follows
  task automatic send_cell(input logic [VAL_W-1:0] value, input logic flush);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cell_value <= value;
    in_if.is_flush <= flush;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (advance_grid(value, flush)) fed_cells++;
  endtask

  // Drop valid, wait for every expected item, then let items without a result drain
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_GRID_COLS:      cfg_cols = data[COLS_CFG_W-1:0];
      REG_GRID_ROWS:      cfg_rows = data[ROWS_W-1:0];
      REG_ALPHA:          cfg_alpha = data[ALPHA_W-1:0];
      REG_BOUNDARY_VALUE: cfg_boundary = data[VAL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_grid(input logic [CFG_DATA_W-1:0] cols, rows, alpha, boundary);
    put_reg(REG_GRID_COLS, cols);
    put_reg(REG_GRID_ROWS, rows);
    put_reg(REG_ALPHA, alpha);
    put_reg(REG_BOUNDARY_VALUE, boundary);
    cfg_we_i <= 1'b0;
  endtask

  // Send whole data rows, with stray flush items mixed in when noisy
  task automatic feed_rows(input int unsigned count, input bit noisy);
    int unsigned cols;
    cols = active_cols();
    for (int unsigned r = 0; r < count; r++) begin
      for (int unsigned c = 0; c < cols; c++) begin
        if (noisy && $urandom_range(0, 24) == 0) send_cell(VAL_W'($urandom), 1'b1);
        send_cell(pick_temp(), 1'b0);
      end
    end
  endtask

  // Drive out the final row, with stray data items mixed in when noisy
  task automatic flush_row(input bit noisy);
    int unsigned cols;
    cols = active_cols();
    for (int unsigned c = 0; c < cols; c++) begin
      if (noisy && $urandom_range(0, 24) == 0) send_cell(pick_temp(), 1'b0);
      send_cell(VAL_W'($urandom), 1'b1);
    end
  endtask

  // A three-column, two-row grid with extreme values: saturation both ways, dropped items
  task automatic test_saturation();
    program_grid(3, 2, 32767, 65535);
    send_cell(16'h0000, 1'b0);
    send_cell(16'hFFFF, 1'b0);
    send_cell(16'h0000, 1'b0);
    send_cell(16'h1234, 1'b1);
    send_cell(16'hFFFF, 1'b0);
    send_cell(16'h0000, 1'b0);
    send_cell(16'hFFFF, 1'b0);
    send_cell(16'hFFFF, 1'b1);
    send_cell(16'hABCD, 1'b0);
    send_cell(16'h0000, 1'b1);
    send_cell(16'h5555, 1'b1);
  endtask

  // Zero column and row counts, a single row, a grid two columns wide
  task automatic test_degenerate_sizes();
    drain_results();
    program_grid(0, 0, 16384, 0);
    send_cell(16'h8000, 1'b0);
    send_cell(16'h0000, 1'b1);
    drain_results();
    program_grid(2, 1, 0, 16'h8001);
    feed_rows(1, 1'b0);
    flush_row(1'b0);
  endtask

  // Shrink the column count inside a row, then the row count down to the rows seen
  task automatic test_midframe_reconfig();
    drain_results();
    program_grid(4, 4095, 9000, 6400);
    feed_rows(1, 1'b0);
    repeat (3) send_cell(pick_temp(), 1'b0);
    drain_results();
    program_grid(3, 4095, 9000, 6400);
    send_cell(pick_temp(), 1'b0);
    drain_results();
    program_grid(3, 2, 9000, 6400);
    flush_row(1'b0);
  endtask

  // Full-width rows: a column count above the buffer depth, then exactly the depth
  task automatic test_wide_rows();
    drain_results();
    steady = 1'b1;
    program_grid(255, 2, 16384, VAL_W'($urandom));
    feed_rows(2, 1'b0);
    flush_row(1'b0);
    steady = 1'b0;
    drain_results();
    program_grid(CFG_DATA_W'(MAX_COLS), 2, CFG_DATA_W'($urandom_range(0, 16384)), 0);
    feed_rows(2, 1'b1);
    flush_row(1'b1);
  endtask

  // Random frames, some back to back, some cut short by a lower row count
  task automatic test_random_frames();
    logic [CFG_DATA_W-1:0] cols_pick;
    logic [CFG_DATA_W-1:0] rows_pick;
    logic [CFG_DATA_W-1:0] alpha_pick;
    logic [CFG_DATA_W-1:0] bv_pick;
    int unsigned           sent_rows;
    bit                    noisy;
    fed_cells = 0;
    while (fed_cells < 500) begin
      if (fed_cells == 0 || $urandom_range(0, 2) != 0) begin
        drain_results();
        case ($urandom_range(0, 19))
          0:       cols_pick = 0;
          1:       cols_pick = CFG_DATA_W'(MAX_COLS);
          2:       cols_pick = 1;
          3:       cols_pick = CFG_DATA_W'($urandom_range(MAX_COLS + 1, 255));
          default: cols_pick = CFG_DATA_W'($urandom_range(2, 12));
        endcase
        rows_pick = (cols_pick >= 64) ? 2 : CFG_DATA_W'($urandom_range(0, 6));
        case ($urandom_range(0, 5))
          0:       alpha_pick = 0;
          1:       alpha_pick = 16384;
          2:       alpha_pick = 32767;
          default: alpha_pick = CFG_DATA_W'($urandom_range(0, 16384));
        endcase
        case ($urandom_range(0, 5))
          0:       bv_pick = 0;
          1:       bv_pick = 65535;
          default: bv_pick = CFG_DATA_W'($urandom_range(0, 65535));
        endcase
        program_grid(cols_pick, rows_pick, alpha_pick, bv_pick);
      end
      steady = ($urandom_range(0, 3) == 0);
      noisy = ($urandom_range(0, 1) == 0);
      if (active_rows() >= 3 && $urandom_range(0, 5) == 0) begin
        sent_rows = $urandom_range(1, active_rows() - 1);
        feed_rows(sent_rows, noisy);
        drain_results();
        program_grid(CFG_DATA_W'(cfg_cols), CFG_DATA_W'($urandom_range(0, sent_rows)),
                     CFG_DATA_W'(cfg_alpha), cfg_boundary);
      end else begin
        feed_rows(active_rows(), noisy);
      end
      flush_row(noisy);
    end
    steady = 1'b0;
  endtask

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.cell_value = '0;
    in_if.is_flush = 1'b0;
    out_if.ready = 1'b1;
    steady = 1'b0;
    mismatches = 0;
    sink_hold = 0;
    fed_cells = 0;
    cfg_cols = GRID_COLS_RST;
    cfg_rows = GRID_ROWS_RST;
    cfg_alpha = ALPHA_RST;
    cfg_boundary = BOUNDARY_VALUE_RST;
    rows_seen = '0;
    col_idx = 0;
    for (int i = 0; i < MAX_COLS; i++) begin
      line_above[i] = '0;
      line_center[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_saturation();
    test_degenerate_sizes();
    test_midframe_reconfig();
    test_wide_rows();
    test_random_frames();

    // Wait out the pipeline before the verdict
    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### heat_diffusion_stencil_step_core.f
rtl/hds_pkg.sv
rtl/hds_if.sv
rtl/hds_linebuf.sv
rtl/hds_alu.sv
rtl/heat_diffusion_stencil_step_core.sv
tb/sv/heat_diffusion_stencil_step_core_tb.sv
